FILE: hdl/fcc_pkg.sv
// Package for the floor and ceiling texel caster.
// Holds item structs, screen and texture constants and the divide-by-five step.
// No dependencies.
`default_nettype none

package fcc_pkg;

  // Screen and texture geometry
  localparam int SCREEN_W     = 640;
  localparam int SCREEN_H     = 480;
  localparam int HALF_H       = SCREEN_H / 2;
  localparam int TEX_BITS     = 6;
  localparam int ADDR_W       = 12;
  localparam int FRAC_BITS    = 16;
  localparam int DIST_W       = 24;
  // 640 << 16 = 5 << 23: floor shift, then floor divide by five
  localparam int DEN_SHIFT    = FRAC_BITS + 7;
  localparam int MAP_MARGIN_X = 20;
  localparam int MAP_MARGIN_Y = 21;
  localparam logic [31:0] DIM_MASK = 32'h007F_7F7F;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_RENDER = 1'b1;
  localparam logic SEL_CEILING = 1'b1;

  typedef enum logic [2:0] {
    CFG_HERO_X   = 3'd0,
    CFG_HERO_Y   = 3'd1,
    CFG_DIR_X    = 3'd2,
    CFG_DIR_Y    = 3'd3,
    CFG_PLANE_X  = 3'd4,
    CFG_PLANE_Y  = 3'd5,
    CFG_MAP_W    = 3'd6,
    CFG_MAP_H    = 3'd7
  } cfg_index_t;

  typedef struct packed {
    logic        kind;
    logic        tex_select;
    logic [11:0] texel_index;
    logic [31:0] texel_value;
    logic [9:0]  pixel_x;
    logic [8:0]  pixel_y;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  out_x;
    logic [8:0]  floor_row;
    logic [8:0]  ceiling_row;
    logic [31:0] floor_color;
    logic [31:0] ceiling_color;
  } out_item_t;

  // Fields that ride alongside the address math
  typedef struct packed {
    logic        is_load;
    logic        tex_select;
    logic [11:0] texel_index;
    logic [31:0] texel_value;
    logic [9:0]  x;
    logic [8:0]  y;
    logic        dim;
  } side_t;

  // Eight restoring steps of a divide by five, MSB first: {quotient bits, remainder}
  function automatic logic [10:0] div5_step8(input logic [2:0] rem_in, input logic [7:0] bits);
    logic [3:0] r;
    logic [7:0] q;
    logic [2:0] rr;
    rr = rem_in;
    q  = '0;
    for (int i = 7; i >= 0; i--) begin
      r = {rr, bits[i]};
      if (r >= 4'd5) begin
        r    = r - 4'd5;
        q[i] = 1'b1;
      end
      rr = r[2:0];
    end
    return {q, rr};
  endfunction

endpackage

`default_nettype wire

FILE: hdl/fcc_axis.sv
// World position and texel coordinate along one axis, nine register stages.
// Depends on fcc_pkg; all stages advance on en.
`default_nettype none

module fcc_axis
  import fcc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic [DIST_W-1:0]    row_dist,
  input  wire logic [9:0]           x,
  input  wire logic signed [32:0]   start,
  input  wire logic signed [32:0]   diff,
  input  wire logic signed [31:0]   hero,
  output logic [TEX_BITS-1:0]       tex
);

  // Stage A: start*640 + x*diff
  logic signed [43:0] a_r, a_nxt;
  logic [DIST_W-1:0]  dist_a_r;
  always_comb begin
    a_nxt = (44'(start) <<< 9) + (44'(start) <<< 7) + $signed({1'b0, x}) * diff;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      a_r      <= a_nxt;
      dist_a_r <= row_dist;
    end
  end

  // Stage M: row distance times the two halves of A
  logic [45:0]        pl_r;
  logic signed [46:0] ph_r;
  always_ff @(posedge clk) begin
    if (en) begin
      pl_r <= dist_a_r * a_r[21:0];
      ph_r <= $signed({1'b0, dist_a_r}) * $signed(a_r[43:22]);
    end
  end

  // Stage N: wrapped 64-bit numerator, floor shift, fold sign
  logic [63:0] num;
  logic [39:0] n_r;
  logic        neg_r;
  always_comb begin
    num = 64'(pl_r) + (64'(ph_r) << 22);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      neg_r <= num[63];
      n_r   <= num[63] ? ~num[62:DEN_SHIFT] : num[62:DEN_SHIFT];
    end
  end

  // Stages D0..D4: divide by five, one byte per stage
  logic [39:0] dn_r  [0:5];
  logic [39:0] dq_r  [0:5];
  logic [2:0]  drm_r [0:5];
  logic        dng_r [0:5];
  always_comb begin
    dn_r[0]  = n_r;
    dq_r[0]  = '0;
    drm_r[0] = '0;
    dng_r[0] = neg_r;
  end
  for (genvar k = 0; k < 5; k++) begin : g_div
    logic [10:0] st;
    assign st = div5_step8(drm_r[k], dn_r[k][39-8*k -: 8]);
    always_ff @(posedge clk) begin
      if (en) begin
        dn_r[k+1]  <= dn_r[k];
        dq_r[k+1]  <= {dq_r[k][31:0], st[10:3]};
        drm_r[k+1] <= st[2:0];
        dng_r[k+1] <= dng_r[k];
      end
    end
  end

  // Stage P: add viewer position, truncate toward zero, mask
  localparam int LSB = FRAC_BITS - TEX_BITS;
  localparam int SGN = 63 - TEX_BITS;
  logic signed [40:0]   fl;
  logic [SGN:0]         pos;
  logic [TEX_BITS-1:0]  tex_r;
  always_comb begin
    fl  = dng_r[5] ? ~$signed({1'b0, dq_r[5]}) : $signed({1'b0, dq_r[5]});
    pos = (SGN+1)'(hero) + (SGN+1)'(fl);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      tex_r <= pos[FRAC_BITS-1:LSB] + TEX_BITS'(pos[SGN] && (pos[LSB-1:0] != '0));
    end
  end
  assign tex = tex_r;

endmodule

`default_nettype wire

FILE: hdl/floor_ceiling_texel_caster.sv
// Floor and ceiling texel caster top level.
// Takes one item per cycle unless a result is stalled at the output.
// Throughput is set by the single shared stall: the whole pipeline holds while a
// result waits. Depth: lookup, 9 address stages, texture read, output register.
// Reset clears the valid bits and the configuration registers; textures are not cleared.
// Depends on fcc_pkg and fcc_axis.
`default_nettype none

module floor_ceiling_texel_caster
  import fcc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_item_t   in_item,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_item_t       out_item,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [31:0] cfg_data
);

  // Configuration registers
  logic signed [31:0] hero_x_r, hero_y_r, dir_x_r, dir_y_r, plane_x_r, plane_y_r;
  logic [9:0]         map_w_r;
  logic [8:0]         map_h_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hero_x_r  <= '0;
      hero_y_r  <= '0;
      dir_x_r   <= '0;
      dir_y_r   <= '0;
      plane_x_r <= '0;
      plane_y_r <= '0;
      map_w_r   <= '0;
      map_h_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_t'(cfg_index))
        CFG_HERO_X:  hero_x_r  <= cfg_data;
        CFG_HERO_Y:  hero_y_r  <= cfg_data;
        CFG_DIR_X:   dir_x_r   <= cfg_data;
        CFG_DIR_Y:   dir_y_r   <= cfg_data;
        CFG_PLANE_X: plane_x_r <= cfg_data;
        CFG_PLANE_Y: plane_y_r <= cfg_data;
        CFG_MAP_W:   map_w_r   <= cfg_data[9:0];
        CFG_MAP_H:   map_h_r   <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Ray start vectors, refreshed every cycle
  logic signed [32:0] sx_r, sy_r;
  always_ff @(posedge clk) begin
    sx_r <= 33'(dir_x_r) - 33'(plane_x_r);
    sy_r <= 33'(dir_y_r) - 33'(plane_y_r);
  end

  // Global advance
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Row distance table
  logic [DIST_W-1:0] dist_tab [0:255];
  for (genvar g = 0; g < 256; g++) begin : g_dist
    localparam logic [DIST_W-1:0] DV =
      (g >= 1 && g < HALF_H) ? DIST_W'((HALF_H << FRAC_BITS) / ((g == 0) ? 1 : g)) : '0;
    assign dist_tab[g] = DV;
  end

  // Stage 1: classify, minimap test, distance lookup
  logic              v_r  [1:11];
  side_t             sb_r [1:11];
  logic [DIST_W-1:0] dist1_r;
  logic              ok_nxt, dim_nxt;
  logic [8:0]        p_nxt;
  always_comb begin
    ok_nxt = (in_item.kind == KIND_LOAD) ||
             (in_item.pixel_y > 9'(HALF_H) && 10'(in_item.pixel_y) < 10'(SCREEN_H) &&
              in_item.pixel_x < 10'(SCREEN_W));
    dim_nxt = (11'(in_item.pixel_x) + 11'(map_w_r) >= 11'(SCREEN_W - MAP_MARGIN_X)) &&
              (in_item.pixel_x <= 10'(SCREEN_W - MAP_MARGIN_X)) &&
              (10'(in_item.pixel_y) + 10'(map_h_r) >= 10'(SCREEN_H - MAP_MARGIN_Y)) &&
              (in_item.pixel_y <= 9'(SCREEN_H - MAP_MARGIN_Y));
    p_nxt = in_item.pixel_y - 9'(HALF_H);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[1] <= 1'b0;
    end else if (en) begin
      v_r[1] <= in_valid && ok_nxt;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[1].is_load     <= (in_item.kind == KIND_LOAD);
      sb_r[1].tex_select  <= in_item.tex_select;
      sb_r[1].texel_index <= in_item.texel_index;
      sb_r[1].texel_value <= in_item.texel_value;
      sb_r[1].x           <= in_item.pixel_x;
      sb_r[1].y           <= in_item.pixel_y;
      sb_r[1].dim         <= dim_nxt;
      dist1_r             <= dist_tab[p_nxt[7:0]];
    end
  end

  // Side fields follow the address math
  for (genvar s = 2; s <= 11; s++) begin : g_side
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_r[s-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sb_r[s] <= sb_r[s-1];
      end
    end
  end

  // Address math, stages 2 to 10
  logic [TEX_BITS-1:0] tx, ty;
  fcc_axis u_axis_x (
    .clk      (clk),
    .en       (en),
    .row_dist (dist1_r),
    .x        (sb_r[1].x),
    .start    (sx_r),
    .diff     ({plane_x_r, 1'b0}),
    .hero     (hero_x_r),
    .tex      (tx)
  );
  fcc_axis u_axis_y (
    .clk      (clk),
    .en       (en),
    .row_dist (dist1_r),
    .x        (sb_r[1].x),
    .start    (sy_r),
    .diff     ({plane_y_r, 1'b0}),
    .hero     (hero_y_r),
    .tex      (ty)
  );

  // Stage 11: texture stores, written and read in the same stage to keep order
  logic [31:0] floor_mem [0:(1<<ADDR_W)-1];
  logic [31:0] ceil_mem  [0:(1<<ADDR_W)-1];
  logic [31:0] frd_r, crd_r;
  logic [ADDR_W-1:0] raddr;
  logic        wr_ok;
  assign raddr = {ty, tx};
  assign wr_ok = en && v_r[10] && sb_r[10].is_load;
  always_ff @(posedge clk) begin
    if (wr_ok && sb_r[10].tex_select != SEL_CEILING) begin
      floor_mem[sb_r[10].texel_index] <= sb_r[10].texel_value;
    end
    if (en) begin
      frd_r <= floor_mem[raddr];
    end
  end
  always_ff @(posedge clk) begin
    if (wr_ok && sb_r[10].tex_select == SEL_CEILING) begin
      ceil_mem[sb_r[10].texel_index] <= sb_r[10].texel_value;
    end
    if (en) begin
      crd_r <= ceil_mem[raddr];
    end
  end

  // Stage 12: output register with minimap dimming
  logic      out_valid_r;
  out_item_t out_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_r[11] && !sb_r[11].is_load;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_r.out_x         <= sb_r[11].x;
      out_r.floor_row     <= sb_r[11].y;
      out_r.ceiling_row   <= 9'(10'(SCREEN_H - 1) - 10'(sb_r[11].y));
      out_r.floor_color   <= frd_r;
      out_r.ceiling_color <= sb_r[11].dim ? ((crd_r >> 1) & DIM_MASK) : crd_r;
    end
  end
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Checks
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked result");
  a_render_out: assert property (@(posedge clk) disable iff (!rst_n)
    (en && v_r[11] && !sb_r[11].is_load) |=> out_valid)
    else $error("render item lost at output");
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (en && v_r[11] && sb_r[11].is_load) |=> !out_valid)
    else $error("load item produced a result");

endmodule

`default_nettype wire

FILE: test/tb_floor_ceiling_texel_caster.sv
// Testbench for floor_ceiling_texel_caster: loads both texture stores, renders
// pixel pairs under several view settings and checks each result against a predictor.
// Depends on fcc_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_floor_ceiling_texel_caster
  import fcc_pkg::*;
();

  localparam int LIMIT = 5000;
  localparam int DRAIN = 30;
  localparam int CHUNK = 110;

  // Predicts results from accepted items and holds them until they come out
  class texel_scoreboard;
    logic [63:0] hero_x, hero_y, dir_x, dir_y, plane_x, plane_y;
    int map_w, map_h;
    logic [31:0] floor_tex[int];
    logic [31:0] ceil_tex[int];
    out_item_t expected_q[$];
    int errors;

    function new();
      {hero_x, hero_y, dir_x, dir_y, plane_x, plane_y} = '0;
      map_w = 0;
      map_h = 0;
      errors = 0;
    endfunction

    function void set_reg(cfg_index_t idx, logic [31:0] d);
      logic [63:0] s;
      s = {{32{d[31]}}, d};
      case (idx)
        CFG_HERO_X:  hero_x = s;
        CFG_HERO_Y:  hero_y = s;
        CFG_DIR_X:   dir_x = s;
        CFG_DIR_Y:   dir_y = s;
        CFG_PLANE_X: plane_x = s;
        CFG_PLANE_Y: plane_y = s;
        CFG_MAP_W:   map_w = d[9:0];
        CFG_MAP_H:   map_h = d[8:0];
        default: ;
      endcase
    endfunction

    // hero + floor((dist*start*W + x*dist*diff) / (W << 16)), all wrapping at 64 bits
    function logic [63:0] world(logic [63:0] hero, start, diff, row_dist, px);
      logic [63:0] num, den, q;
      num = row_dist * start * 64'd640 + px * row_dist * diff;
      den = 64'd640 << FRAC_BITS;
      q = num[63] ? (64'd0 - ((~num) / den) - 64'd1) : num / den;
      return hero + q;
    endfunction

    // truncate toward zero, keep the low texel bits
    function int tex_coord(logic [63:0] p);
      logic [63:0] v, t;
      v = p * 64'd64;
      t = v[63] ? 64'd0 - ((~v + 64'd1) >> FRAC_BITS) : v >> FRAC_BITS;
      return int'(t[5:0]);
    endfunction

    function int texel_addr(int x, int y);
      logic [63:0] row_dist, sx, sy, dx, dy;
      row_dist = (64'(HALF_H) << FRAC_BITS) / 64'(y - HALF_H);
      sx = dir_x - plane_x;
      sy = dir_y - plane_y;
      dx = (dir_x + plane_x) - sx;
      dy = (dir_y + plane_y) - sy;
      return tex_coord(world(hero_y, sy, dy, row_dist, 64'(y) * 0 + 64'(x))) * 64
           + tex_coord(world(hero_x, sx, dx, row_dist, 64'(x)));
    endfunction

    function void note(in_item_t it);
      out_item_t e;
      int a, x, y;
      if (it.kind == KIND_LOAD) begin
        if (it.tex_select == SEL_CEILING) ceil_tex[it.texel_index] = it.texel_value;
        else floor_tex[it.texel_index] = it.texel_value;
        return;
      end
      x = it.pixel_x;
      y = it.pixel_y;
      if (y <= HALF_H || y >= SCREEN_H || x >= SCREEN_W) return;
      a = texel_addr(x, y);
      e.out_x = it.pixel_x;
      e.floor_row = it.pixel_y;
      e.ceiling_row = 9'(SCREEN_H - y - 1);
      e.floor_color = floor_tex.exists(a) ? floor_tex[a] : 32'd0;
      e.ceiling_color = ceil_tex.exists(a) ? ceil_tex[a] : 32'd0;
      // dimmed minimap box near the bottom right
      if (SCREEN_W - map_w - MAP_MARGIN_X <= x && x <= SCREEN_W - MAP_MARGIN_X &&
          SCREEN_H - map_h - MAP_MARGIN_Y <= y && y <= SCREEN_H - MAP_MARGIN_Y)
        e.ceiling_color = (e.ceiling_color >> 1) & DIM_MASK;
      expected_q.push_back(e);
    endfunction

    function void check(out_item_t got);
      out_item_t e;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      e = expected_q.pop_front();
      if (got.out_x != e.out_x || got.floor_row != e.floor_row ||
          got.ceiling_row != e.ceiling_row || got.floor_color != e.floor_color ||
          got.ceiling_color != e.ceiling_color) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p, got %p", e, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  texel_scoreboard sb = new();
  bit floor_loaded[4096];
  bit ceil_loaded[4096];
  bit quiet = 1'b0;
  bit long_hold = 1'b0;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  floor_ceiling_texel_caster DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Monitor both channels and the watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note(in_item);
      if (out_valid && !out_stall) sb.check(out_item);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= LIMIT) begin
        $display("timeout");
        $display("tb_floor_ceiling_texel_caster: FAIL");
        $finish;
      end
    end
  end

  // Receiver: short random stalls, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (200) @(posedge clk);
        long_hold = 1'b0;
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one item; returns just after the edge that took it
  task automatic send(in_item_t it);
    bit taken;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic send_load(bit sel, int idx, logic [31:0] val);
    in_item_t it;
    it = in_item_t'(65'({$urandom, $urandom, $urandom}));
    it.kind = KIND_LOAD;
    it.tex_select = sel;
    it.texel_index = 12'(idx);
    it.texel_value = val;
    if (sel == SEL_CEILING) ceil_loaded[idx] = 1'b1;
    else floor_loaded[idx] = 1'b1;
    send(it);
  endtask

  // Renders that land on an empty texel get that texel loaded first
  task automatic send_render(int x, int y);
    in_item_t it;
    int a;
    it = in_item_t'(65'({$urandom, $urandom, $urandom}));
    it.kind = KIND_RENDER;
    it.pixel_x = 10'(x);
    it.pixel_y = 9'(y);
    if (y > HALF_H && y < SCREEN_H && x < SCREEN_W) begin
      a = sb.texel_addr(x, y);
      if (!floor_loaded[a]) send_load(1'b0, a, $urandom);
      if (!ceil_loaded[a]) send_load(SEL_CEILING, a, $urandom);
    end
    send(it);
  endtask

  // Holds cfg_valid high; the caller drops it after the last write
  task automatic write_reg(cfg_index_t idx, logic [31:0] d);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    sb.set_reg(idx, d);
  endtask

  // Drain the pipeline, then load a whole view setting
  task automatic set_view(logic [31:0] hx, hy, dx, dy, px, py, int mw, int mh);
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    write_reg(CFG_HERO_X, hx);
    write_reg(CFG_HERO_Y, hy);
    write_reg(CFG_DIR_X, dx);
    write_reg(CFG_DIR_Y, dy);
    write_reg(CFG_PLANE_X, px);
    write_reg(CFG_PLANE_Y, py);
    write_reg(CFG_MAP_W, 32'(mw));
    write_reg(CFG_MAP_H, 32'(mh));
    cfg_valid <= 1'b0;
  endtask

  task automatic random_items(int n);
    int r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 15) send_load(1'($urandom_range(0, 1)), $urandom_range(0, 4095), $urandom);
      else if (r < 90) send_render($urandom_range(0, SCREEN_W - 1),
                                   $urandom_range(HALF_H + 1, SCREEN_H - 1));
      else send_render($urandom_range(0, 1023), $urandom_range(0, 511));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, horizon and off-screen cases
    set_view(32'h0016_8000, 32'h000B_8000, 32'hFFFF_0000, 32'h0, 32'h0, 32'h0000_A8F6,
             128, 96);
    send_load(1'b0, 0, 32'h0);
    send_load(SEL_CEILING, 4095, 32'hFFFF_FFFF);
    send_render(0, HALF_H + 1);
    send_render(SCREEN_W - 1, SCREEN_H - 1);
    send_render(0, SCREEN_H - 1);
    send_render(SCREEN_W - 1, HALF_H + 1);
    send_render(SCREEN_W - MAP_MARGIN_X, SCREEN_H - MAP_MARGIN_Y);
    send_render(SCREEN_W - 128 - MAP_MARGIN_X, SCREEN_H - 96 - MAP_MARGIN_Y);
    send_render(SCREEN_W - 129 - MAP_MARGIN_X, SCREEN_H - 20);
    send_render(100, HALF_H);
    send_render(100, 0);
    send_render(100, SCREEN_H);
    send_render(SCREEN_W, 300);
    send_render(1023, 511);

    random_items(CHUNK);

    // Largest positive registers, minimap sized to the screen
    set_view(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h7FFF_FFFF, SCREEN_W, SCREEN_H);
    long_hold = 1'b1;
    random_items(CHUNK);

    // Most negative registers, minimap width and height zero
    set_view(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h8000_0000, 0, 0);
    random_items(CHUNK);

    repeat (2) begin
      set_view($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom_range(0, SCREEN_W), $urandom_range(0, SCREEN_H));
      random_items(CHUNK);
    end

    // Last part without idling on either side
    set_view($urandom_range(0, 32'h00FF_FFFF), $urandom_range(0, 32'h00FF_FFFF),
             32'(int'($urandom_range(0, 32'h0002_0000)) - 32'h0001_0000),
             32'(int'($urandom_range(0, 32'h0002_0000)) - 32'h0001_0000),
             $urandom_range(0, 32'h0001_0000), $urandom_range(0, 32'h0001_0000),
             $urandom_range(0, SCREEN_W), $urandom_range(0, SCREEN_H));
    quiet = 1'b1;
    random_items(CHUNK);

    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (sb.errors == 0)
      $display("tb_floor_ceiling_texel_caster: PASS");
    else
      $display("tb_floor_ceiling_texel_caster: FAIL");
    $finish;
  end

endmodule

FILE: sim.f
hdl/fcc_pkg.sv
hdl/fcc_axis.sv
hdl/floor_ceiling_texel_caster.sv
test/tb_floor_ceiling_texel_caster.sv
